@@ rtl/bbl_pkg.sv @@
// Shared types, constants and arithmetic helpers for the biquad low-pass block.
package bbl_pkg;

   localparam int CHANNELS = 6;
   localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CHAN_W   = 3;
   localparam int SAMPLE_W = 32;
   localparam int COEF_W   = 32;
   localparam int LIMIT_W  = 31;
   localparam int CSR_IDX_W = 2;
   localparam int PROD_W   = SAMPLE_W + COEF_W;
   localparam int RND_W    = 35;
   localparam int ACC_W    = 36;

   localparam logic signed [COEF_W-1:0]  INVERSE_GAIN_RST   = 32'sd104830570;
   localparam logic signed [COEF_W-1:0]  FEEDBACK_OLDER_RST = -32'sd357913941;
   localparam logic signed [COEF_W-1:0]  FEEDBACK_NEWER_RST = 32'sd1012333500;
   localparam logic        [LIMIT_W-1:0] SETTLE_LIMIT_RST   = 31'd327680;

   localparam logic signed [ACC_W-1:0] SAT_MAX = 36'sh0_7FFF_FFFF;
   localparam logic signed [ACC_W-1:0] SAT_MIN = 36'shF_8000_0000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INVERSE_GAIN   = 2'd0,
      CSR_FEEDBACK_OLDER = 2'd1,
      CSR_FEEDBACK_NEWER = 2'd2,
      CSR_SETTLE_LIMIT   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] inverse_gain;
      logic signed [COEF_W-1:0] feedback_older;
      logic signed [COEF_W-1:0] feedback_newer;
      logic [LIMIT_W-1:0]       settle_limit;
   } cfg_type;

   // per-channel filter history, one memory word
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] y2;
      logic signed [SAMPLE_W-1:0] y1;
      logic signed [SAMPLE_W-1:0] x2;
      logic signed [SAMPLE_W-1:0] x1;
   } hist_type;

   localparam int HIST_W = $bits(hist_type);

   typedef struct packed {
      logic                       saturated;
      logic                       passed_raw;
      logic signed [SAMPLE_W-1:0] filtered;
      logic [CHAN_W-1:0]          channel;
   } rsp_item_type;

   typedef struct packed {
      logic                       clipped;
      logic signed [SAMPLE_W-1:0] value;
   } sat_type;

   function automatic logic chan_in_range(input logic [CHAN_W-1:0] ch);
      return 32'(ch) < CHANNELS;
   endfunction

   function automatic logic [CH_IDX_W-1:0] chan_idx(input logic [CHAN_W-1:0] ch);
      return chan_in_range(ch) ? CH_IDX_W'(ch) : '0;
   endfunction

   // Q2.30 x Q16.16 product back to Q16.16, round half up
   function automatic logic signed [RND_W-1:0] round_q30(input logic signed [PROD_W-1:0] p);
      logic signed [RND_W-1:0] hi;
      logic signed [RND_W-1:0] inc;
      hi  = RND_W'($signed(p[PROD_W-1:30]));
      inc = {{(RND_W-1){1'b0}}, p[29]};
      return hi + inc;
   endfunction

   function automatic sat_type sat32(input logic signed [ACC_W-1:0] v);
      sat_type r;
      r.clipped = 1'b1;
      if (v > SAT_MAX) begin
         r.value = SAT_MAX[SAMPLE_W-1:0];
      end else if (v < SAT_MIN) begin
         r.value = SAT_MIN[SAMPLE_W-1:0];
      end else begin
         r.value   = v[SAMPLE_W-1:0];
         r.clipped = 1'b0;
      end
      return r;
   endfunction

endpackage

@@ rtl/butterworth_biquad_lowpass_channels.sv @@
// Pipeline: an accepted transaction passes 3 stages (B, C, D) plus output register to rsp_tvalid.
// Throughput: one transaction per cycle across distinct channels unless the output stalls; a channel
// in stages B to D is held off by the read-modify-write loop on the per-channel history memory.
// Reset: clears pipeline and output valids, all channel primed flags, and config defaults.
// History memory is not cleared; an unprimed channel's first sample overwrites its entry.
module butterworth_biquad_lowpass_channels import bbl_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [31:0]          req_tdata,   // [31:0] sample_in
   input  logic [CHAN_W-1:0]    req_tuser,   // [2:0] channel
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [31:0]          rsp_tdata,   // [31:0] filtered
   output logic [4:0]           rsp_tuser,   // [2:0] channel_out, [3] passed_raw, [4] saturated
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COEF_W-1:0]    csr_wr_data
);

   cfg_type      cfg;
   logic         core_valid, core_ready;
   rsp_item_type core_item;
   logic         rsp_vld_ff;
   rsp_item_type rsp_item_ff;

   bbl_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (csr_wr_en),
      .index   (csr_index),
      .wr_data (csr_wr_data),
      .cfg     (cfg)
   );

   bbl_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_channel (req_tuser),
      .in_sample  ($signed(req_tdata)),
      .out_valid  (core_valid),
      .out_ready  (core_ready),
      .out_item   (core_item)
   );

   assign core_ready = !rsp_vld_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (core_ready) begin
         rsp_vld_ff <= core_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (core_ready && core_valid) begin
         rsp_item_ff <= core_item;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_item_ff.filtered;
   assign rsp_tuser  = {rsp_item_ff.saturated, rsp_item_ff.passed_raw, rsp_item_ff.channel};

   // same channel cannot be taken again the cycle after a transaction
   a_chan_interlock: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=>
         !(req_tvalid && req_tready && (req_tuser == $past(req_tuser))))
      else $error("back-to-back transaction on one channel");

   a_sat_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[4]) |-> chan_in_range(rsp_tuser[2:0]))
      else $error("saturation reported for unmapped channel");

   a_unmapped_raw: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !chan_in_range(rsp_tuser[2:0])) |-> rsp_tuser[3])
      else $error("unmapped channel not passed raw");

endmodule

@@ rtl/bbl_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module bbl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/bbl_csr.sv @@
// Configuration registers: filter coefficients and settle limit.
module bbl_csr import bbl_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  logic [CSR_IDX_W-1:0] index,
   input  logic [COEF_W-1:0]    wr_data,
   output cfg_type              cfg
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.inverse_gain   <= INVERSE_GAIN_RST;
         cfg_ff.feedback_older <= FEEDBACK_OLDER_RST;
         cfg_ff.feedback_newer <= FEEDBACK_NEWER_RST;
         cfg_ff.settle_limit   <= SETTLE_LIMIT_RST;
      end else if (wr_en) begin
         unique case (csr_index_type'(index))
            CSR_INVERSE_GAIN:   cfg_ff.inverse_gain   <= $signed(wr_data);
            CSR_FEEDBACK_OLDER: cfg_ff.feedback_older <= $signed(wr_data);
            CSR_FEEDBACK_NEWER: cfg_ff.feedback_newer <= $signed(wr_data);
            CSR_SETTLE_LIMIT:   cfg_ff.settle_limit   <= wr_data[LIMIT_W-1:0];
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/bbl_core.sv @@
// Filter pipeline: history memory read, feedback products, sum, saturate and write back.
module bbl_core import bbl_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  cfg_type                    cfg,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic [CHAN_W-1:0]          in_channel,
   input  logic signed [SAMPLE_W-1:0] in_sample,
   output logic                       out_valid,
   input  logic                       out_ready,
   output rsp_item_type               out_item
);

   logic accept, hazard;
   logic b_go, c_go, d_go;

   // stage B: history word arrives from memory
   logic                       b_vld_ff;
   logic [CHAN_W-1:0]          b_ch_ff;
   logic signed [SAMPLE_W-1:0] b_sample_ff;
   logic signed [PROD_W-1:0]   b_xprod_ff;
   logic signed [PROD_W-1:0]   xprod_in;
   logic [HIST_W-1:0]          ram_rd_data;
   hist_type                   b_hist;
   logic                       b_inr, b_primed;
   sat_type                    b_xn;

   // stage C: products ready, form the sum
   logic                       c_vld_ff;
   logic [CHAN_W-1:0]          c_ch_ff;
   logic signed [SAMPLE_W-1:0] c_sample_ff;
   logic                       c_inr_ff, c_primed_ff;
   hist_type                   c_hist_ff;
   logic signed [SAMPLE_W-1:0] c_xn_ff;
   logic signed [PROD_W-1:0]   c_pold_ff, c_pnew_ff;
   logic signed [ACC_W-1:0]    acc_in;

   // stage D: saturate, jump test, write back
   logic                       d_vld_ff;
   logic [CHAN_W-1:0]          d_ch_ff;
   logic signed [SAMPLE_W-1:0] d_sample_ff;
   logic                       d_inr_ff, d_primed_ff;
   hist_type                   d_hist_ff;
   logic signed [SAMPLE_W-1:0] d_xn_ff;
   logic signed [ACC_W-1:0]    d_acc_ff;
   sat_type                    d_y;
   logic signed [SAMPLE_W:0]   d_diff;
   logic [SAMPLE_W:0]          d_absdiff;
   logic                       d_jump;
   logic                       wb_en;
   hist_type                   wb_hist;

   logic [CHANNELS-1:0]        primed_ff;

   assign d_go   = !d_vld_ff || out_ready;
   assign c_go   = !c_vld_ff || d_go;
   assign b_go   = !b_vld_ff || c_go;

   // read-modify-write interlock: one transaction per channel in flight
   assign hazard = (b_vld_ff && (b_ch_ff == in_channel)) ||
                   (c_vld_ff && (c_ch_ff == in_channel)) ||
                   (d_vld_ff && (d_ch_ff == in_channel));
   assign in_ready = b_go && !hazard;
   assign accept   = in_valid && in_ready;

   assign xprod_in = PROD_W'(in_sample) * PROD_W'(cfg.inverse_gain);

   bbl_ram #(
      .WIDTH (HIST_W),
      .DEPTH (CHANNELS)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (wb_en),
      .wr_addr (chan_idx(d_ch_ff)),
      .wr_data (wb_hist),
      .rd_en   (accept),
      .rd_addr (chan_idx(in_channel)),
      .rd_data (ram_rd_data)
   );

   assign b_hist   = hist_type'(ram_rd_data);
   assign b_inr    = chan_in_range(b_ch_ff);
   assign b_primed = b_inr && primed_ff[chan_idx(b_ch_ff)];
   assign b_xn     = sat32(ACC_W'(round_q30(b_xprod_ff)));

   assign acc_in = ACC_W'(c_hist_ff.x2) + (ACC_W'(c_hist_ff.x1) <<< 1) + ACC_W'(c_xn_ff)
                 + ACC_W'(round_q30(c_pold_ff)) + ACC_W'(round_q30(c_pnew_ff));

   assign d_y       = sat32(d_acc_ff);
   assign d_diff    = (SAMPLE_W+1)'(d_y.value) - (SAMPLE_W+1)'(d_hist_ff.y1);
   assign d_absdiff = d_diff[SAMPLE_W] ? $unsigned(-d_diff) : $unsigned(d_diff);
   assign d_jump    = d_absdiff > (SAMPLE_W+1)'(cfg.settle_limit);

   assign wb_en = d_vld_ff && d_go && d_inr_ff;

   always_comb begin
      if (d_primed_ff) begin
         wb_hist.x1 = d_xn_ff;
         wb_hist.x2 = d_hist_ff.x1;
         wb_hist.y1 = d_y.value;
         wb_hist.y2 = d_hist_ff.y1;
      end else begin
         wb_hist.x1 = d_sample_ff;
         wb_hist.x2 = d_sample_ff;
         wb_hist.y1 = d_sample_ff;
         wb_hist.y2 = d_sample_ff;
      end
   end

   always_comb begin
      out_item.channel = d_ch_ff;
      if (d_inr_ff && d_primed_ff) begin
         out_item.saturated  = d_y.clipped;
         out_item.passed_raw = d_jump;
         out_item.filtered   = d_jump ? d_sample_ff : d_y.value;
      end else begin
         out_item.saturated  = 1'b0;
         out_item.passed_raw = 1'b1;
         out_item.filtered   = d_sample_ff;
      end
   end

   assign out_valid = d_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff  <= 1'b0;
         c_vld_ff  <= 1'b0;
         d_vld_ff  <= 1'b0;
         primed_ff <= '0;
      end else begin
         if (b_go) begin
            b_vld_ff <= accept;
         end
         if (c_go) begin
            c_vld_ff <= b_vld_ff;
         end
         if (d_go) begin
            d_vld_ff <= c_vld_ff;
         end
         if (wb_en) begin
            primed_ff[chan_idx(d_ch_ff)] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b_ch_ff     <= in_channel;
         b_sample_ff <= in_sample;
         b_xprod_ff  <= xprod_in;
      end
      if (c_go) begin
         c_ch_ff     <= b_ch_ff;
         c_sample_ff <= b_sample_ff;
         c_inr_ff    <= b_inr;
         c_primed_ff <= b_primed;
         c_hist_ff   <= b_hist;
         c_xn_ff     <= b_xn.value;
         c_pold_ff   <= PROD_W'(cfg.feedback_older) * PROD_W'(b_hist.y2);
         c_pnew_ff   <= PROD_W'(cfg.feedback_newer) * PROD_W'(b_hist.y1);
      end
      if (d_go) begin
         d_ch_ff     <= c_ch_ff;
         d_sample_ff <= c_sample_ff;
         d_inr_ff    <= c_inr_ff;
         d_primed_ff <= c_primed_ff;
         d_hist_ff   <= c_hist_ff;
         d_xn_ff     <= c_xn_ff;
         d_acc_ff    <= acc_in;
      end
   end

endmodule
